// ===== sv/sapc_pkg.sv =====
// ----------------------------------------------------------------------------
// sapc_pkg: shared types and constants for the source address packet counter
// Holds the command and result codes, the field widths and the record that
// travels down the chain of table cells.
// ----------------------------------------------------------------------------
package sapc_pkg;

    localparam int ADDR_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int SLOT_W          = 6;
    localparam int USED_W          = 7;
    localparam int TABLE_DEPTH_DEF = 64;

    typedef enum logic
    {
        CMD_COUNT = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_HIT   = 3'd0,
        ST_NEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_READ  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // One item in flight along the chain, with the result gathered so far.
    typedef struct packed
    {
        cmd_t               cmd;
        logic [ADDR_W-1:0]  key;
        logic [SLOT_W-1:0]  rslot;
        logic               done;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } item_t;

endpackage

// ===== sv/sapc_cell.sv =====
// ----------------------------------------------------------------------------
// sapc_cell: one table slot of the packet counter chain
// Holds one address and its count, acts on the item passing through and
// registers the item for the next cell.
// ----------------------------------------------------------------------------
module sapc_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  sapc_pkg::item_t     in_item,
    input  logic [CNT_W-1:0]    in_used,
    output logic                out_valid,
    output sapc_pkg::item_t     out_item,
    output logic [CNT_W-1:0]    out_used
);

    localparam int SLOT_W = sapc_pkg::SLOT_W;
    localparam int COUNT_W = sapc_pkg::COUNT_W;
    localparam logic [SLOT_W-1:0] IDX_LOW = SLOT_W'(IDX);
    localparam bit READABLE = (IDX < (1 << SLOT_W));

    logic                          occ_reg, occ_next;
    logic [sapc_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [COUNT_W-1:0]            cnt_reg, cnt_next;
    logic                          valid_reg;
    sapc_pkg::item_t               item_reg, item_next;
    logic [CNT_W-1:0]              used_reg, used_next;
    logic [COUNT_W-1:0]            cnt_inc;

    assign cnt_inc = (cnt_reg == {COUNT_W{1'b1}}) ? cnt_reg : cnt_reg + COUNT_W'(1);

    always_comb
    begin
        item_next = in_item;
        used_next = in_used;
        occ_next  = occ_reg;
        addr_next = addr_reg;
        cnt_next  = cnt_reg;
        if (in_valid)
        begin
            if (occ_reg)
            begin
                used_next = in_used + CNT_W'(1);
            end
            if (in_item.cmd == sapc_pkg::CMD_READ)
            begin
                if (READABLE && occ_reg && (in_item.rslot == IDX_LOW))
                begin
                    item_next.done   = 1'b1;
                    item_next.status = sapc_pkg::ST_READ;
                    item_next.slot   = IDX_LOW;
                    item_next.addr   = addr_reg;
                    item_next.count  = cnt_reg;
                end
            end
            else if (!in_item.done)
            begin
                if (occ_reg && (addr_reg == in_item.key))
                begin
                    cnt_next         = cnt_inc;
                    item_next.done   = 1'b1;
                    item_next.status = sapc_pkg::ST_HIT;
                    item_next.slot   = IDX_LOW;
                    item_next.addr   = addr_reg;
                    item_next.count  = cnt_inc;
                end
                else if (!occ_reg)
                begin
                    // First free slot in the row: the address settles here.
                    occ_next         = 1'b1;
                    addr_next        = in_item.key;
                    cnt_next         = COUNT_W'(1);
                    used_next        = in_used + CNT_W'(1);
                    item_next.done   = 1'b1;
                    item_next.status = sapc_pkg::ST_NEW;
                    item_next.slot   = IDX_LOW;
                    item_next.addr   = in_item.key;
                    item_next.count  = COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            occ_reg   <= occ_next;
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg <= addr_next;
            cnt_reg  <= cnt_next;
            item_reg <= item_next;
            used_reg <= used_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_used  = used_reg;

endmodule

// ===== sv/source_address_packet_counter.sv =====
// ----------------------------------------------------------------------------
// source_address_packet_counter: per-source IPv4 packet counting table
// A row of table cells, one per slot, with items moving down the row.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  input    in_valid / in_ready  cmd, src_addr, read_slot
//  output   out_valid/ out_ready status, slot, entry_addr, entry_count,
//                                entries_used
//
//  A transfer is accepted every cycle unless the output is stalled; each item
//  moves through the cells in order, one cell a cycle while the row advances.
//  The register of the last cell serves as the output register.
//  Reset empties the table at once: every cell's occupied flag and every
//  stage's valid flag are cleared, so no clearing pass is needed.
//  While a result waits untaken the whole row holds still, and in_ready falls.
//
// The table is a chain of cells. Each cell owns one slot: its address, its
// count and an occupied flag. Slots fill from cell 0 upward, so the occupied
// cells always form an unbroken run at the head of the row.
//
// An item enters cell 0 and moves one cell per cycle unless stalled. A count
// item compares its address with every occupied cell it passes; on a match
// that cell bumps its count (saturating) and the item takes the new count
// along. If it meets the first free cell without a match, that cell takes the
// address with a count of one. A read item picks up the contents of the cell
// whose index it names, if that cell is occupied. Items never overtake each
// other, so a later item always sees every change made by items ahead of it.
//
// Each item also counts the occupied cells it passes. Cells ahead of it can
// only be filled by earlier items, and cells behind it only by later ones,
// so that tally is exactly the occupancy the item should report.
//
// An item that leaves the last cell unfinished was either a count item that
// found the table full, or a read of a slot that is empty or out of range;
// the output stage fills in those results.
// ----------------------------------------------------------------------------
module source_address_packet_counter #(
    parameter int TABLE_DEPTH = sapc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [sapc_pkg::ADDR_W-1:0]     src_addr,
    input  logic [sapc_pkg::SLOT_W-1:0]     read_slot,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [sapc_pkg::SLOT_W-1:0]     slot,
    output logic [sapc_pkg::ADDR_W-1:0]     entry_addr,
    output logic [sapc_pkg::COUNT_W-1:0]    entry_count,
    output logic [sapc_pkg::USED_W-1:0]     entries_used
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int USED_W = sapc_pkg::USED_W;

    logic                   stage_valid [0:TABLE_DEPTH];
    sapc_pkg::item_t        stage_item  [0:TABLE_DEPTH];
    logic [CNT_W-1:0]       stage_used  [0:TABLE_DEPTH];
    logic                   advance;
    sapc_pkg::item_t        head_item;
    sapc_pkg::item_t        tail;

    // The whole row moves only when the last cell's result can leave.
    assign advance  = !stage_valid[TABLE_DEPTH] || out_ready;
    assign in_ready = advance;

    // Fresh item entering the head of the row, with no result gathered yet.
    always_comb
    begin
        head_item        = '0;
        head_item.cmd    = sapc_pkg::cmd_t'(cmd);
        head_item.key    = src_addr;
        head_item.rslot  = read_slot;
        head_item.done   = 1'b0;
        head_item.status = sapc_pkg::ST_FULL;
    end
    assign stage_item[0]  = head_item;
    assign stage_valid[0] = in_valid;
    assign stage_used[0]  = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        sapc_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (stage_valid[g]),
            .in_item   (stage_item[g]),
            .in_used   (stage_used[g]),
            .out_valid (stage_valid[g+1]),
            .out_item  (stage_item[g+1]),
            .out_used  (stage_used[g+1])
        );
    end

    // Results for items that passed the whole row without finishing.
    always_comb
    begin
        tail = stage_item[TABLE_DEPTH];
        if (!tail.done)
        begin
            if (tail.cmd == sapc_pkg::CMD_COUNT)
            begin
                tail.status = sapc_pkg::ST_FULL;
                tail.slot   = '0;
                tail.addr   = tail.key;
                tail.count  = '0;
            end
            else
            begin
                tail.status = sapc_pkg::ST_EMPTY;
                tail.slot   = tail.rslot;
                tail.addr   = '0;
                tail.count  = '0;
            end
        end
    end

    assign out_valid    = stage_valid[TABLE_DEPTH];
    assign status       = tail.status;
    assign slot         = tail.slot;
    assign entry_addr   = tail.addr;
    assign entry_count  = tail.count;
    assign entries_used = USED_W'(stage_used[TABLE_DEPTH]);

    // The occupancy tally can never pass the number of cells.
    a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stage_used[TABLE_DEPTH] <= CNT_W'(TABLE_DEPTH)))
        else $error("occupancy tally exceeds table depth");

    // A dropped packet is only reported when every slot is taken.
    a_full_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sapc_pkg::ST_FULL) |->
        (stage_used[TABLE_DEPTH] == CNT_W'(TABLE_DEPTH)))
        else $error("table full reported with free slots");

    // A freshly placed address always starts at a count of one.
    a_new_count_one : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sapc_pkg::ST_NEW) |->
        (entry_count == sapc_pkg::COUNT_W'(1) && stage_used[TABLE_DEPTH] != '0))
        else $error("new entry with wrong count or empty table");

    // A counted hit never reports a zero count.
    a_hit_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sapc_pkg::ST_HIT) |-> (entry_count != '0))
        else $error("hit reported with zero count");

endmodule
